// File: rtl/bhpq_pkg.sv
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int unsigned HeapDepthDefault = 1024;
  localparam int unsigned KeyW             = 32;
  localparam int unsigned PAddrW           = 3;
  localparam int unsigned PDataW           = 32;

  typedef enum logic [0:0] {
    REG_HEAP_ORDER = 1'b0
  } reg_idx_e;

  typedef enum logic [0:0] {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    ORDER_MIN = 1'b0,
    ORDER_MAX = 1'b1
  } order_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_LD,
    S_DN_CHK,
    S_DN_CMP
  } state_e;

  typedef struct packed {
    func_e                  func;
    logic signed [KeyW-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [KeyW-1:0] top_value;
    status_e                status;
  } result_t;

  // True when key a must sit strictly above key b in the given order.
  function automatic logic preferred(order_e order, logic signed [KeyW-1:0] a,
                                     logic signed [KeyW-1:0] b);
    logic res;
    res = (order == ORDER_MAX) ? (b < a) : (a < b);
    return res;
  endfunction

endpackage

// File: rtl/binary_heap_priority_queue.sv
`timescale 1ns / 1ps

// Binary heap priority queue, min or max order chosen by the heap_order register.
// An item is a command: raise start with item_i; it is taken when busy is low.
// func insert pushes value, func extract pops the top key. Every command gives
// exactly one result: result_valid_o is high for one cycle with result_o,
// which the receiver must take then, as it has no way to hold results off.
// A full insert or an empty extract answers in the next cycle without
// raising busy. A real insert climbs the heap, reading the parent in
// S_UP_CHK and comparing and writing back in S_UP_CMP for each level; an
// extract takes root and last key in S_EX_LD, then descends, reading both
// children in S_DN_CHK and comparing in S_DN_CMP for each level. Each level
// is paced by the heap memory: it needs one registered read before the compare
// and the write-back. The result appears in the same cycle that busy falls.
// The APB port holds heap_order at byte address 0; changing it does not
// reorder keys already held. Reset empties the heap and selects min order;
// the memory itself is not cleared, as slots are only read once written.
module binary_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = bhpq_pkg::HeapDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bhpq_pkg::item_t                 item_i,
  output logic                            result_valid_o,
  output bhpq_pkg::result_t               result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bhpq_pkg::PAddrW-1:0]     paddr,
  input  logic [bhpq_pkg::PDataW-1:0]     pwdata,
  output logic [bhpq_pkg::PDataW-1:0]     prdata,
  output logic                            pready
);

  import bhpq_pkg::*;

  localparam int unsigned AddrW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HEAP_DEPTH + 1);

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [AddrW-1:0]       pos_q, pos_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [KeyW-1:0] top_q, top_d;
  order_e                 order_q;
  logic                   res_valid_q, res_valid_d;
  result_t                res_q, res_d;

  logic [KeyW-1:0]        heap_mem_q [HEAP_DEPTH];
  logic signed [KeyW-1:0] rd_a_q, rd_b_q;
  logic [AddrW-1:0]       rd_a_addr, rd_b_addr, wr_addr;
  logic                   wr_en;
  logic signed [KeyW-1:0] wr_data;

  logic                   accept;
  logic                   cfg_wr;
  logic [CntW:0]          left_w, right_w;
  logic                   right_ok, pick_right;
  logic signed [KeyW-1:0] pick_val;
  logic [AddrW-1:0]       pick_addr, parent_addr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_MIN;
    end else if (cfg_wr && (paddr[2] == REG_HEAP_ORDER)) begin
      order_q <= order_e'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HEAP_ORDER) begin
      prdata = PDataW'(order_q);
    end
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= heap_mem_q[rd_a_addr];
    rd_b_q <= heap_mem_q[rd_b_addr];
  end

  assign accept = start & ~busy;
  assign busy   = (state_q != S_IDLE);

  assign left_w      = ((CntW + 1)'(pos_q) << 1) | (CntW + 1)'(1);
  assign right_w     = left_w + (CntW + 1)'(1);
  assign right_ok    = right_w < (CntW + 1)'(count_q);
  assign pick_right  = right_ok && preferred(order_q, rd_b_q, rd_a_q);
  assign pick_val    = pick_right ? rd_b_q : rd_a_q;
  assign pick_addr   = pick_right ? right_w[AddrW-1:0] : left_w[AddrW-1:0];
  assign parent_addr = (pos_q - AddrW'(1)) >> 1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    key_d       = key_q;
    top_d       = top_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = key_q;
    rd_a_addr   = left_w[AddrW-1:0];
    rd_b_addr   = right_w[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.func == FUNC_INSERT) begin
            if (count_q == CntW'(HEAP_DEPTH)) begin
              res_valid_d = 1'b1;
              res_d       = '{top_value: '0, status: ST_FULL};
            end else begin
              pos_d   = count_q[AddrW-1:0];
              key_d   = item_i.value;
              count_d = count_q + CntW'(1);
              state_d = S_UP_CHK;
            end
          end else begin
            if (count_q == '0) begin
              res_valid_d = 1'b1;
              res_d       = '{top_value: '0, status: ST_EMPTY};
            end else begin
              rd_a_addr = '0;
              rd_b_addr = AddrW'(count_q - CntW'(1));
              count_d   = count_q - CntW'(1);
              state_d   = S_EX_LD;
            end
          end
        end
      end

      // The new key is carried in key_q; the hole at pos_q moves up.
      S_UP_CHK: begin
        if (pos_q == '0) begin
          wr_en       = 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{top_value: '0, status: ST_OK};
          state_d     = S_IDLE;
        end else begin
          rd_a_addr = parent_addr;
          state_d   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (preferred(order_q, key_q, rd_a_q)) begin
          wr_data = rd_a_q;
          pos_d   = parent_addr;
          state_d = S_UP_CHK;
        end else begin
          res_valid_d = 1'b1;
          res_d       = '{top_value: '0, status: ST_OK};
          state_d     = S_IDLE;
        end
      end

      S_EX_LD: begin
        top_d   = rd_a_q;
        key_d   = rd_b_q;
        pos_d   = '0;
        state_d = S_DN_CHK;
      end

      // The former last key sinks from the root; children are read together.
      S_DN_CHK: begin
        if (left_w >= (CntW + 1)'(count_q)) begin
          wr_en       = 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{top_value: top_q, status: ST_OK};
          state_d     = S_IDLE;
        end else begin
          state_d = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        wr_en = 1'b1;
        if (preferred(order_q, pick_val, key_q)) begin
          wr_data = pick_val;
          pos_d   = pick_addr;
          state_d = S_DN_CHK;
        end else begin
          res_valid_d = 1'b1;
          res_d       = '{top_value: top_q, status: ST_OK};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    key_q <= key_d;
    top_q <= top_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Assertions

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(HEAP_DEPTH))
    else $error("element count exceeds heap depth");

  a_full_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.func == FUNC_INSERT && count_q == CntW'(HEAP_DEPTH))
    |=> (result_valid_o && result_o.status == ST_FULL && !busy))
    else $error("insert on a full heap not answered as full");

  a_empty_extract : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.func == FUNC_EXTRACT && count_q == '0)
    |=> (result_valid_o && result_o.status == ST_EMPTY && result_o.top_value == '0))
    else $error("extract on an empty heap not answered as empty");

  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) || $past(accept)))
    else $error("result transfer without a command in progress");

endmodule
